// File: rtl/nfca_pkg.sv
// Shared types and constants for the NFC-A UID cascade select sequencer.
// Used by every module under rtl; depends on nothing else.
package nfca_pkg;

    // Largest UID the scan may gather, in bytes.
    localparam int UID_BYTES_MAX = 10;

    // Widths fixed by the item fields.
    localparam int CNT_W  = 4;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    // Frame outcome codes carried on the input side.
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_ATQA     = 3'd1;
    localparam logic [2:0] CMD_ANTICOLL = 3'd2;
    localparam logic [2:0] CMD_SELECT   = 3'd3;
    localparam logic [2:0] CMD_FAIL     = 3'd4;

    // Answer lengths expected for each frame kind.
    localparam logic [LEN_W-1:0] ATQA_LEN     = 6'd2;
    localparam logic [LEN_W-1:0] ANTICOLL_LEN = 6'd5;
    localparam logic [LEN_W-1:0] SAK_LEN      = 6'd1;

    // Protocol byte values.
    localparam logic [7:0] SEL_CL1     = 8'h93;
    localparam logic [7:0] SEL_CL2     = 8'h95;
    localparam logic [7:0] SEL_CL3     = 8'h97;
    localparam logic [7:0] CASCADE_TAG = 8'h88;
    localparam logic [7:0] SAK_CASCADE = 8'h04;

    // Largest starting counts that still leave room for a cascade or final part.
    localparam logic [CNT_W-1:0] CNT_MAX_CASCADE = CNT_W'(UID_BYTES_MAX - 3);
    localparam logic [CNT_W-1:0] CNT_MAX_FINAL   = CNT_W'(UID_BYTES_MAX - 4);

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_ATQA     = 2'd1,
        PH_ANTICOLL = 2'd2,
        PH_SAK      = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ACT_REQA     = 3'd0,
        ACT_ANTICOLL = 3'd1,
        ACT_SELECT   = 3'd2,
        ACT_OK       = 3'd3,
        ACT_FAIL     = 3'd4
    } act_t;

    // One result item as it travels to the output stage.
    typedef struct packed {
        act_t                  action;
        logic [7:0]            select_code;
        logic [4:0][7:0]       frame;
        logic [CNT_W-1:0]      uid_length;
        logic [63:0]           uid_low;
        logic [15:0]           uid_high;
        logic [7:0]            sak_value;
        logic [15:0]           atqa_value;
    } res_t;

    // Select code for a cascade level; levels past the third use the last code.
    function automatic logic [7:0] level_code(input logic [1:0] level);
        logic [7:0] code;
        case (level)
            2'd0:    code = SEL_CL1;
            2'd1:    code = SEL_CL2;
            default: code = SEL_CL3;
        endcase
        return code;
    endfunction

endpackage

// File: rtl/nfca_seq.sv
// Identification sequencer state and its update per frame outcome.
// Depends on nfca_pkg.
module nfca_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [2:0]         command,
    input  logic [5:0]         rx_len,
    input  logic [4:0][7:0]    rx_bytes,
    input  logic               deadline_passed,
    output logic               res_valid,
    output nfca_pkg::res_t     res
);

    nfca_pkg::phase_t phase_reg, phase_next;
    logic [1:0]       level_reg, level_next;
    logic [nfca_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]       uid_reg  [nfca_pkg::UID_BYTES_MAX];
    logic [7:0]       uid_next [nfca_pkg::UID_BYTES_MAX];
    logic [4:0][7:0]  saved_reg, saved_next;
    logic [15:0]      atqa_reg, atqa_next;
    logic [7:0]       sak_reg, sak_next;

    nfca_pkg::act_t   action;
    logic             produce;
    logic             append_en;
    logic [2:0]       append_n;
    logic [3:0][7:0]  append_src;
    logic [7:0]       check;

    assign check = rx_bytes[0] ^ rx_bytes[1] ^ rx_bytes[2] ^ rx_bytes[3];

    // Next state and the action for the current frame outcome.
    always_comb
    begin
        phase_next = phase_reg;
        level_next = level_reg;
        count_next = count_reg;
        saved_next = saved_reg;
        atqa_next  = atqa_reg;
        sak_next   = sak_reg;
        for (int j = 0; j < nfca_pkg::UID_BYTES_MAX; j++)
        begin
            uid_next[j] = uid_reg[j];
        end
        produce    = 1'b0;
        action     = nfca_pkg::ACT_REQA;
        append_en  = 1'b0;
        append_n   = 3'd4;
        append_src = saved_reg[3:0];

        case (command)
            nfca_pkg::CMD_START:
            begin
                for (int j = 0; j < nfca_pkg::UID_BYTES_MAX; j++)
                begin
                    uid_next[j] = 8'h00;
                end
                count_next = '0;
                atqa_next  = 16'h0000;
                sak_next   = 8'h00;
                level_next = 2'd0;
                phase_next = nfca_pkg::PH_ATQA;
                produce    = 1'b1;
                action     = nfca_pkg::ACT_REQA;
            end
            nfca_pkg::CMD_ATQA:
            begin
                if (phase_reg == nfca_pkg::PH_ATQA)
                begin
                    produce = 1'b1;
                    if (rx_len == nfca_pkg::ATQA_LEN)
                    begin
                        atqa_next  = {rx_bytes[1], rx_bytes[0]};
                        level_next = 2'd0;
                        phase_next = nfca_pkg::PH_ANTICOLL;
                        action     = nfca_pkg::ACT_ANTICOLL;
                    end
                    else if (deadline_passed)
                    begin
                        phase_next = nfca_pkg::PH_IDLE;
                        action     = nfca_pkg::ACT_FAIL;
                    end
                    else
                    begin
                        action = nfca_pkg::ACT_REQA;
                    end
                end
            end
            nfca_pkg::CMD_ANTICOLL:
            begin
                if (phase_reg == nfca_pkg::PH_ANTICOLL)
                begin
                    produce = 1'b1;
                    if (rx_len != nfca_pkg::ANTICOLL_LEN || check != rx_bytes[4])
                    begin
                        phase_next = nfca_pkg::PH_IDLE;
                        action     = nfca_pkg::ACT_FAIL;
                    end
                    else
                    begin
                        saved_next = rx_bytes;
                        phase_next = nfca_pkg::PH_SAK;
                        action     = nfca_pkg::ACT_SELECT;
                    end
                end
            end
            nfca_pkg::CMD_SELECT:
            begin
                if (phase_reg == nfca_pkg::PH_SAK)
                begin
                    produce    = 1'b1;
                    phase_next = nfca_pkg::PH_IDLE;
                    action     = nfca_pkg::ACT_FAIL;
                    if (rx_len == nfca_pkg::SAK_LEN)
                    begin
                        sak_next = rx_bytes[0];
                        if (saved_reg[0] == nfca_pkg::CASCADE_TAG)
                        begin
                            // Cascade part: three UID bytes follow the tag.
                            if (count_reg <= nfca_pkg::CNT_MAX_CASCADE &&
                                (rx_bytes[0] & nfca_pkg::SAK_CASCADE) != 8'h00)
                            begin
                                append_en  = 1'b1;
                                append_n   = 3'd3;
                                append_src = {8'h00, saved_reg[3:1]};
                                count_next = count_reg + nfca_pkg::CNT_W'(3);
                                if (level_reg < 2'd2)
                                begin
                                    level_next = level_reg + 2'd1;
                                    phase_next = nfca_pkg::PH_ANTICOLL;
                                    action     = nfca_pkg::ACT_ANTICOLL;
                                end
                            end
                        end
                        else if (count_reg <= nfca_pkg::CNT_MAX_FINAL &&
                                 (rx_bytes[0] & nfca_pkg::SAK_CASCADE) == 8'h00)
                        begin
                            // Final part: four UID bytes and the scan is done.
                            append_en  = 1'b1;
                            append_n   = 3'd4;
                            append_src = saved_reg[3:0];
                            count_next = count_reg + nfca_pkg::CNT_W'(4);
                            action     = nfca_pkg::ACT_OK;
                        end
                    end
                end
            end
            nfca_pkg::CMD_FAIL:
            begin
                case (phase_reg)
                    nfca_pkg::PH_ATQA:
                    begin
                        produce = 1'b1;
                        if (deadline_passed)
                        begin
                            phase_next = nfca_pkg::PH_IDLE;
                            action     = nfca_pkg::ACT_FAIL;
                        end
                        else
                        begin
                            action = nfca_pkg::ACT_REQA;
                        end
                    end
                    nfca_pkg::PH_ANTICOLL, nfca_pkg::PH_SAK:
                    begin
                        produce    = 1'b1;
                        phase_next = nfca_pkg::PH_IDLE;
                        action     = nfca_pkg::ACT_FAIL;
                    end
                    default:
                    begin
                        produce = 1'b0;
                    end
                endcase
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase

        // Append the new UID bytes after those already gathered.
        if (append_en)
        begin
            for (int j = 0; j < nfca_pkg::UID_BYTES_MAX; j++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (3'(i) < append_n &&
                        5'(j) == ({1'b0, count_reg} + 5'(i)))
                    begin
                        uid_next[j] = append_src[i];
                    end
                end
            end
        end
    end

    // Result fields show the state as it stands after this outcome.
    always_comb
    begin
        res.action      = action;
        res.select_code = (action == nfca_pkg::ACT_ANTICOLL ||
                           action == nfca_pkg::ACT_SELECT) ?
                          nfca_pkg::level_code(level_next) : 8'h00;
        res.frame       = (action == nfca_pkg::ACT_SELECT) ? saved_next : '0;
        res.uid_length  = count_next;
        res.uid_low     = 64'h0;
        res.uid_high    = 16'h0;
        for (int j = 0; j < nfca_pkg::UID_BYTES_MAX; j++)
        begin
            if (j < 8)
            begin
                res.uid_low[8*j +: 8] = uid_next[j];
            end
            else
            begin
                res.uid_high[8*(j-8) +: 8] = uid_next[j];
            end
        end
        res.sak_value  = sak_next;
        res.atqa_value = atqa_next;
    end

    assign res_valid = accept & produce;

    // State registers advance only on an accepted transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nfca_pkg::PH_IDLE;
            level_reg <= 2'd0;
            count_reg <= '0;
            saved_reg <= '0;
            atqa_reg  <= 16'h0000;
            sak_reg   <= 8'h00;
            for (int j = 0; j < nfca_pkg::UID_BYTES_MAX; j++)
            begin
                uid_reg[j] <= 8'h00;
            end
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            level_reg <= level_next;
            count_reg <= count_next;
            saved_reg <= saved_next;
            atqa_reg  <= atqa_next;
            sak_reg   <= sak_next;
            for (int j = 0; j < nfca_pkg::UID_BYTES_MAX; j++)
            begin
                uid_reg[j] <= uid_next[j];
            end
        end
    end

endmodule

// File: rtl/nfca_out_buf.sv
// Two-entry result stage: an output register backed by a skid register.
// Depends on nfca_pkg for the result type.
module nfca_out_buf
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  nfca_pkg::res_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output nfca_pkg::res_t out_data
);

    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    nfca_pkg::res_t main_reg, main_next;
    nfca_pkg::res_t skid_reg, skid_next;
    logic           pop;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign pop       = main_valid_reg & out_ready;

    // Move results forward; the skid entry fills only when the output stalls.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Occupancy flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/nfca_uid_cascade_select.sv
// Top level of the NFC-A UID cascade select sequencer.
// Depends on nfca_pkg, nfca_seq and nfca_out_buf.
//
// Each input transfer carries the outcome of one frame exchange (start, ATQA,
// anticollision answer, select answer or failure): the sequencer state updates
// at the accepting edge and the result, if any, lands in a two-entry output
// stage. A new item can be accepted in every cycle; s_tready drops only while
// two results wait for the downstream side. An outcome that does not fit the
// current phase yields no result. Each result names the next frame to send
// (REQA, anticollision, select) or ends the scan with done ok or done failed,
// and always carries the UID, SAK and ATQA.
module nfca_uid_cascade_select
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // rx_len[5:0], rx_byte0[13:6], rx_byte1[21:14], rx_byte2[29:22],
    // rx_byte3[37:30], rx_byte4[45:38], deadline_passed[46], zero[47]
    input  logic [47:0]  s_tdata,
    // command[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // select_code[7:0], frame_byte0[15:8], frame_byte1[23:16],
    // frame_byte2[31:24], frame_byte3[39:32], frame_check[47:40],
    // uid_length[51:48], uid_low[115:52], uid_high[131:116],
    // sak_value[139:132], atqa_value[155:140], zero[159:156]
    output logic [159:0] m_tdata,
    // action[2:0]
    output logic [2:0]   m_tuser
);

    logic            accept;
    logic [4:0][7:0] rx_bytes;
    logic            res_valid;
    nfca_pkg::res_t  res;
    nfca_pkg::res_t  out_res;

    assign accept   = s_tvalid & s_tready;
    assign rx_bytes = s_tdata[45:6];

    // Sequencer state and per-item update.
    nfca_seq u_seq
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .command         (s_tuser),
        .rx_len          (s_tdata[5:0]),
        .rx_bytes        (rx_bytes),
        .deadline_passed (s_tdata[46]),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Result register with skid entry.
    nfca_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result for the output transfer.
    assign m_tuser = out_res.action;
    assign m_tdata = {4'h0,
                      out_res.atqa_value,
                      out_res.sak_value,
                      out_res.uid_high,
                      out_res.uid_low,
                      out_res.uid_length,
                      out_res.frame,
                      out_res.select_code};

endmodule

// File: verif/tb_nfca_uid_cascade_select.sv
`timescale 1ns / 1ps
// Self-checking testbench for nfca_uid_cascade_select: directed and random frame outcomes.
// Keeps its own reader state to predict each next frame; needs nfca_pkg and the RTL top.
module tb_nfca_uid_cascade_select;
    import nfca_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 26;
    localparam int PRINT_LIMIT = 40;

    // Command codes the block does not define; they must be ignored.
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [2:0]   m_tuser;

    // Reader state as the block should hold it.
    phase_t       rd_phase  = PH_IDLE;
    logic [1:0]   rd_level  = '0;
    logic [7:0]   rd_uid[UID_BYTES_MAX] = '{default: 8'h00};
    logic [3:0]   rd_count  = '0;
    logic [7:0]   rd_answer[5] = '{default: 8'h00};
    logic [15:0]  rd_atqa   = '0;
    logic [7:0]   rd_sak    = '0;

    res_t         frames_due[$];
    bit           steady = 1'b0;
    int           cycle_count    = 0;
    int           mismatches     = 0;
    int           items_sent     = 0;
    int           results_caused = 0;
    int           frames_checked = 0;
    int           scans_ok       = 0;
    int           scans_failed   = 0;

    nfca_uid_cascade_select DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frames still due",
                     cycle_count, frames_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Downstream side stalls at random except during the steady stretch.
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Build the frame the reader names for an action from the current state.
    function automatic res_t frame_for(input act_t act);
        res_t r;
        r = '0;
        r.action = act;
        if (act == ACT_ANTICOLL || act == ACT_SELECT)
        begin
            case (rd_level)
                2'd0:    r.select_code = SEL_CL1;
                2'd1:    r.select_code = SEL_CL2;
                default: r.select_code = SEL_CL3;
            endcase
        end
        for (int i = 0; i < 5; i++)
            r.frame[i] = (act == ACT_SELECT) ? rd_answer[i] : 8'h00;
        r.uid_length = rd_count;
        for (int i = 0; i < UID_BYTES_MAX; i++)
        begin
            if (i < 8)
                r.uid_low[8*i +: 8] = rd_uid[i];
            else
                r.uid_high[8*(i-8) +: 8] = rd_uid[i];
        end
        r.sak_value  = rd_sak;
        r.atqa_value = rd_atqa;
        return r;
    endfunction

    // A scan that ends goes back to idle.
    function automatic res_t finish_scan(input act_t act);
        rd_phase = PH_IDLE;
        return frame_for(act);
    endfunction

    // Apply one frame outcome to the reader state and work out the next frame, if any.
    task automatic advance_reader(input logic [2:0] cmd, input logic [5:0] len,
                                  input logic [4:0][7:0] rx, input logic deadline,
                                  output bit has_frame, output res_t r);
        has_frame = 1'b1;
        r = '0;
        if (cmd == CMD_START)
        begin
            rd_uid   = '{default: 8'h00};
            rd_count = '0;
            rd_atqa  = '0;
            rd_sak   = '0;
            rd_level = '0;
            rd_phase = PH_ATQA;
            r = frame_for(ACT_REQA);
        end
        else if (rd_phase == PH_ATQA && (cmd == CMD_ATQA || cmd == CMD_FAIL))
        begin
            if (cmd == CMD_ATQA && len == ATQA_LEN)
            begin
                rd_atqa  = {rx[1], rx[0]};
                rd_level = '0;
                rd_phase = PH_ANTICOLL;
                r = frame_for(ACT_ANTICOLL);
            end
            else if (deadline)
                r = finish_scan(ACT_FAIL);
            else
                r = frame_for(ACT_REQA);
        end
        else if (rd_phase == PH_ANTICOLL && (cmd == CMD_ANTICOLL || cmd == CMD_FAIL))
        begin
            if (cmd == CMD_FAIL || len != ANTICOLL_LEN ||
                (rx[0] ^ rx[1] ^ rx[2] ^ rx[3]) != rx[4])
                r = finish_scan(ACT_FAIL);
            else
            begin
                for (int i = 0; i < 5; i++)
                    rd_answer[i] = rx[i];
                rd_phase = PH_SAK;
                r = frame_for(ACT_SELECT);
            end
        end
        else if (rd_phase == PH_SAK && (cmd == CMD_SELECT || cmd == CMD_FAIL))
        begin
            if (cmd == CMD_FAIL || len != SAK_LEN)
                r = finish_scan(ACT_FAIL);
            else
            begin
                // The SAK is kept even when its cascade bit disagrees.
                rd_sak = rx[0];
                if (rd_answer[0] == CASCADE_TAG)
                begin
                    if (rd_count > CNT_MAX_CASCADE || (rx[0] & SAK_CASCADE) == 8'h00)
                        r = finish_scan(ACT_FAIL);
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            rd_uid[rd_count + 4'(i)] = rd_answer[1 + i];
                        rd_count = rd_count + 4'd3;
                        // A cascade tag at the third level cannot be followed.
                        if (rd_level >= 2'd2)
                            r = finish_scan(ACT_FAIL);
                        else
                        begin
                            rd_level = rd_level + 2'd1;
                            rd_phase = PH_ANTICOLL;
                            r = frame_for(ACT_ANTICOLL);
                        end
                    end
                end
                else if (rd_count > CNT_MAX_FINAL || (rx[0] & SAK_CASCADE) != 8'h00)
                    r = finish_scan(ACT_FAIL);
                else
                begin
                    for (int i = 0; i < 4; i++)
                        rd_uid[rd_count + 4'(i)] = rd_answer[i];
                    rd_count = rd_count + 4'd4;
                    r = finish_scan(ACT_OK);
                end
            end
        end
        else
            has_frame = 1'b0;
    endtask

    // Send one frame outcome, with random idle cycles ahead of it.
    task automatic send_outcome(input logic [2:0] cmd, input logic [5:0] len,
                                input logic [4:0][7:0] rx, input logic deadline);
        bit   has_frame;
        res_t r;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, deadline, rx[4], rx[3], rx[2], rx[1], rx[0], len};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        advance_reader(cmd, len, rx, deadline, has_frame, r);
        if (has_frame)
        begin
            frames_due.push_back(r);
            results_caused++;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("mismatch on %s: got %h, expected %h (frame %0d, t=%0t)",
                     what, got, want, frames_checked, $realtime);
    endtask

    // Compare each result transfer with the oldest frame due.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frames_due.size() == 0)
                report_mismatch("transfer with no frame due", {61'd0, m_tuser}, 64'd0);
            else
            begin
                want = frames_due.pop_front();
                if (m_tuser != want.action)
                    report_mismatch("action", 64'(m_tuser), 64'(want.action));
                if (m_tdata[7:0] != want.select_code)
                    report_mismatch("select_code", 64'(m_tdata[7:0]),
                                    64'(want.select_code));
                for (int i = 0; i < 5; i++)
                    if (m_tdata[8 + 8*i +: 8] != want.frame[i])
                        report_mismatch($sformatf("frame byte %0d", i),
                                        64'(m_tdata[8 + 8*i +: 8]), 64'(want.frame[i]));
                if (m_tdata[51:48] != want.uid_length)
                    report_mismatch("uid_length", 64'(m_tdata[51:48]),
                                    64'(want.uid_length));
                if (m_tdata[115:52] != want.uid_low)
                    report_mismatch("uid_low", m_tdata[115:52], want.uid_low);
                if (m_tdata[131:116] != want.uid_high)
                    report_mismatch("uid_high", 64'(m_tdata[131:116]),
                                    64'(want.uid_high));
                if (m_tdata[139:132] != want.sak_value)
                    report_mismatch("sak_value", 64'(m_tdata[139:132]),
                                    64'(want.sak_value));
                if (m_tdata[155:140] != want.atqa_value)
                    report_mismatch("atqa_value", 64'(m_tdata[155:140]),
                                    64'(want.atqa_value));
                if (want.action == ACT_OK)
                    scans_ok++;
                else if (want.action == ACT_FAIL)
                    scans_failed++;
            end
            frames_checked++;
        end
    end

    // Anticollision answer with a matching check byte.
    function automatic logic [4:0][7:0] answer_of(input logic [7:0] b0, input logic [7:0] b1,
                                                   input logic [7:0] b2, input logic [7:0] b3);
        return {b0 ^ b1 ^ b2 ^ b3, b3, b2, b1, b0};
    endfunction

    function automatic logic [4:0][7:0] random_bytes();
        logic [4:0][7:0] v;
        for (int i = 0; i < 5; i++)
            v[i] = 8'($urandom_range(255));
        return v;
    endfunction

    // Well-formed answer; a cascade part starts with the tag, a final part never does.
    function automatic logic [4:0][7:0] random_answer(input bit cascade);
        logic [7:0] b0;
        b0 = 8'($urandom_range(255));
        if (cascade)
            b0 = CASCADE_TAG;
        else if (b0 == CASCADE_TAG)
            b0 = b0 ^ 8'($urandom_range(1, 255));
        return answer_of(b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
    endfunction

    function automatic logic [5:0] wrong_len(input logic [5:0] good);
        logic [5:0] l;
        do l = 6'($urandom_range(32)); while (l == good);
        return l;
    endfunction

    task automatic send_noise();
        send_outcome(3'($urandom_range(7)), 6'($urandom_range(32)), random_bytes(),
                     1'($urandom_range(1)));
    endtask

    task automatic maybe_noise();
        if ($urandom_range(99) < 6)
            send_noise();
    endtask

    // One scan with random content; most run clean, a few break at a random step.
    task automatic random_scan();
        int              levels;
        int              pick;
        bit              cascade;
        logic [4:0][7:0] rx;
        logic [7:0]      sak;
        send_outcome(CMD_START, 6'($urandom_range(32)), random_bytes(), 1'($urandom_range(1)));
        repeat ($urandom_range(0, 2))
        begin
            maybe_noise();
            if ($urandom_range(1))
                send_outcome(CMD_FAIL, 6'($urandom_range(32)), random_bytes(), 1'b0);
            else
                send_outcome(CMD_ATQA, wrong_len(ATQA_LEN), random_bytes(), 1'b0);
        end
        if ($urandom_range(99) < 8)
        begin
            send_outcome(CMD_FAIL, 6'($urandom_range(32)), random_bytes(), 1'b1);
            return;
        end
        send_outcome(CMD_ATQA, ATQA_LEN, random_bytes(), 1'($urandom_range(1)));
        levels = $urandom_range(1, 3);
        if ($urandom_range(99) < 6)
            levels = 4;
        for (int lvl = 0; lvl < 3 && lvl < levels; lvl++)
        begin
            cascade = (lvl < levels - 1);
            maybe_noise();
            rx = random_answer(cascade);
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                rx[4] = rx[4] ^ (8'h01 << $urandom_range(7));
                send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, rx, 1'($urandom_range(1)));
                return;
            end
            else if (pick < 6)
            begin
                send_outcome(CMD_ANTICOLL, wrong_len(ANTICOLL_LEN), rx, 1'($urandom_range(1)));
                return;
            end
            else if (pick < 8)
            begin
                send_outcome(CMD_FAIL, 6'($urandom_range(32)), rx, 1'($urandom_range(1)));
                return;
            end
            send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, rx, 1'($urandom_range(1)));
            maybe_noise();
            rx = random_bytes();
            sak = rx[0];
            sak[2] = cascade;
            pick = $urandom_range(99);
            if (pick < 4)
                sak[2] = !cascade;
            rx[0] = sak;
            if (pick < 4)
            begin
                send_outcome(CMD_SELECT, SAK_LEN, rx, 1'($urandom_range(1)));
                return;
            end
            else if (pick < 6)
            begin
                send_outcome(CMD_SELECT, wrong_len(SAK_LEN), rx, 1'($urandom_range(1)));
                return;
            end
            else if (pick < 8)
            begin
                send_outcome(CMD_FAIL, 6'($urandom_range(32)), rx, 1'($urandom_range(1)));
                return;
            end
            send_outcome(CMD_SELECT, SAK_LEN, rx, 1'($urandom_range(1)));
        end
    endtask

    // REQA retries, the deadline, and a reserved command code.
    task automatic test_request_retries();
        send_outcome(CMD_START, 6'd32, {5{8'hFF}}, 1'b1);
        send_outcome(CMD_RSVD5, 6'd0, {5{8'h00}}, 1'b0);
        send_outcome(CMD_FAIL, 6'd0, {5{8'h00}}, 1'b0);
        send_outcome(CMD_ATQA, 6'd3, {5{8'h55}}, 1'b0);
        send_outcome(CMD_FAIL, 6'd31, {5{8'hAA}}, 1'b1);
    endtask

    // Full three-level scan to a 10-byte UID, with an out-of-phase command on the way.
    task automatic test_cascade_levels();
        send_outcome(CMD_START, 6'd0, {5{8'h00}}, 1'b0);
        send_outcome(CMD_ATQA, ATQA_LEN, {8'h00, 8'h00, 8'h00, 8'h00, 8'h44}, 1'b1);
        send_outcome(CMD_SELECT, SAK_LEN, {5{8'hFF}}, 1'b0);
        send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, answer_of(CASCADE_TAG, 8'h01, 8'h02, 8'h03),
                     1'b0);
        send_outcome(CMD_SELECT, SAK_LEN, {5{8'hFF}}, 1'b0);
        send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, answer_of(CASCADE_TAG, 8'h04, 8'h05, 8'h06),
                     1'b0);
        send_outcome(CMD_SELECT, SAK_LEN, {8'h00, 8'h00, 8'h00, 8'h00, SAK_CASCADE}, 1'b0);
        send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, answer_of(8'h07, 8'h08, 8'h09, 8'h0A), 1'b0);
        send_outcome(CMD_SELECT, SAK_LEN, {5{8'h00}}, 1'b0);
    endtask

    // Broken anticollision and select answers, and a cascade bit that disagrees.
    task automatic test_answer_errors();
        send_outcome(CMD_START, 6'd0, {5{8'h00}}, 1'b0);
        send_outcome(CMD_ATQA, ATQA_LEN, {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF}, 1'b0);
        send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, {8'h01, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0);
        send_outcome(CMD_START, 6'd0, {5{8'h00}}, 1'b0);
        send_outcome(CMD_ATQA, ATQA_LEN, {5{8'h00}}, 1'b0);
        send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, answer_of(8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
        send_outcome(CMD_SELECT, 6'd0, {5{8'h00}}, 1'b0);
        send_outcome(CMD_START, 6'd0, {5{8'h00}}, 1'b0);
        send_outcome(CMD_ATQA, ATQA_LEN, {5{8'h12}}, 1'b0);
        send_outcome(CMD_RSVD7, ANTICOLL_LEN, {5{8'hFF}}, 1'b1);
        send_outcome(CMD_ANTICOLL, ANTICOLL_LEN, answer_of(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0);
        send_outcome(CMD_SELECT, SAK_LEN, {8'h00, 8'h00, 8'h00, 8'h00, SAK_CASCADE}, 1'b0);
        send_outcome(CMD_RSVD6, 6'd1, {5{8'h00}}, 1'b0);
    endtask

    // Random scans at full rate on both sides.
    task automatic test_back_to_back();
        int target;
        target = items_sent + 150;
        steady = 1'b1;
        while (items_sent < target)
            random_scan();
        steady = 1'b0;
    endtask

    // Random scans under random idling and stalls.
    task automatic test_random_scans();
        int target;
        target = items_sent + 1250;
        while (items_sent < target)
            random_scan();
    endtask

    // Unstructured outcomes, mostly out of phase.
    task automatic test_random_noise();
        int target;
        target = items_sent + 220;
        while (items_sent < target)
            send_noise();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_request_retries();
        test_cascade_levels();
        test_answer_errors();
        test_back_to_back();
        test_random_scans();
        test_random_noise();

        s_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d frame outcomes and checked %0d reader frames.",
                 items_sent, frames_checked);
        $display("Scans ended %0d times with a UID and %0d times in failure.",
                 scans_ok, scans_failed);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
